@@ rtl/touch_auto_repeat_clock_control_defines.svh @@
// Assertion macros shared by the touch auto-repeat clock control RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TOUCH_AUTO_REPEAT_CLOCK_CONTROL_DEFINES_SVH
`define TOUCH_AUTO_REPEAT_CLOCK_CONTROL_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define TARCC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define TARCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TARCC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define TARCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ rtl/tarcc_pkg.sv @@
// Shared types and constants for the touch auto-repeat clock control block.
// Used by tarcc_fsm and the top level; no dependencies.
package tarcc_pkg;

    localparam int CNT_W  = 8;
    localparam int ADDR_W = 2;

    localparam logic [CNT_W-1:0] SETTLE_TICKS_RST = 8'd1;
    localparam logic [CNT_W-1:0] HOLD_TICKS_RST   = 8'd10;
    localparam logic [CNT_W-1:0] REPEAT_TICKS_RST = 8'd1;
    localparam logic [CNT_W-1:0] SECOND_TICKS_RST = 8'd20;

    localparam logic [ADDR_W-1:0] REG_SETTLE = 2'd0;
    localparam logic [ADDR_W-1:0] REG_HOLD   = 2'd1;
    localparam logic [ADDR_W-1:0] REG_REPEAT = 2'd2;
    localparam logic [ADDR_W-1:0] REG_SECOND = 2'd3;

    typedef enum logic [2:0] {
        PH_INIT    = 3'd0,
        PH_NEVER   = 3'd1,
        PH_WAIT    = 3'd2,
        PH_SETTLE  = 3'd3,
        PH_HOLD    = 3'd4,
        PH_REPEAT  = 3'd5,
        PH_REP_EXP = 3'd6,
        PH_ADD_SEC = 3'd7
    } phase_t;

    typedef struct packed {
        logic [CNT_W-1:0] settle_ticks;
        logic [CNT_W-1:0] hold_ticks;
        logic [CNT_W-1:0] repeat_ticks;
        logic [CNT_W-1:0] second_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t phase;
        logic   touch_ack;
        logic   advance_second;
        logic   inc_dec_pulse;
    } result_t;

endpackage

@@ rtl/touch_auto_repeat_clock_control.sv @@
// Touch auto-repeat clock control: one tick beat in, one result beat out.
// Latency: a result beat is valid on the cycle after its tick is accepted.
// Throughput: one tick per cycle unless a pending result is held by m_tready;
// tarcc_fsm's update is combinational and the result register frees as it is taken.
// Reset (aresetn, synchronous, active low): phase init, counters zero,
// registers at their defaults, no result beat pending.
module touch_auto_repeat_clock_control (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] touched, [7:1] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] inc_dec_pulse, [1] advance_second, [2] touch_ack, [5:3] phase, [7:6] zero
    output logic [7:0]                     m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [tarcc_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [tarcc_pkg::CNT_W-1:0]    cfg_wdata
);
    import tarcc_pkg::*;

    cfg_t    cfg_reg;
    result_t fsm_result;
    result_t result_reg;
    logic    m_tvalid_reg;
    logic    step_en;

    // A new tick is taken whenever the result register is empty or draining.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign step_en  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ticks <= SETTLE_TICKS_RST;
            cfg_reg.hold_ticks   <= HOLD_TICKS_RST;
            cfg_reg.repeat_ticks <= REPEAT_TICKS_RST;
            cfg_reg.second_ticks <= SECOND_TICKS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SETTLE: cfg_reg.settle_ticks <= cfg_wdata;
                REG_HOLD:   cfg_reg.hold_ticks   <= cfg_wdata;
                REG_REPEAT: cfg_reg.repeat_ticks <= cfg_wdata;
                REG_SECOND: cfg_reg.second_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tarcc_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .touched (s_tdata[0]),
        .cfg     (cfg_reg),
        .result  (fsm_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step_en) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            result_reg <= fsm_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, result_reg};

endmodule

@@ rtl/tarcc_fsm.sv @@
// Phase machine and tick counters of the touch auto-repeat clock control.
// Depends on tarcc_pkg and touch_auto_repeat_clock_control_defines.svh.
`include "touch_auto_repeat_clock_control_defines.svh"

module tarcc_fsm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic              touched,
    input  tarcc_pkg::cfg_t   cfg,
    output tarcc_pkg::result_t result
);
    import tarcc_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] settle_count_reg, settle_count_next;
    logic [CNT_W-1:0] hold_count_reg, hold_count_next;
    logic [CNT_W-1:0] repeat_count_reg, repeat_count_next;
    logic [CNT_W-1:0] second_count_reg, second_count_next;
    logic             inc_dec, adv, ack;

    always_comb begin
        phase_next        = phase_reg;
        settle_count_next = settle_count_reg;
        hold_count_next   = hold_count_reg;
        repeat_count_next = repeat_count_reg;
        second_count_next = second_count_reg;
        inc_dec           = 1'b0;
        adv               = 1'b0;
        ack               = 1'b0;

        // Phase actions come first; the transition tests see the updated counts.
        case (phase_reg)
            PH_WAIT: begin
                settle_count_next = '0;
                hold_count_next   = '0;
                repeat_count_next = '0;
                second_count_next = second_count_reg + 1'b1;
            end
            PH_SETTLE:  settle_count_next = settle_count_reg + 1'b1;
            PH_HOLD:    hold_count_next   = hold_count_reg + 1'b1;
            PH_REPEAT:  repeat_count_next = repeat_count_reg + 1'b1;
            PH_REP_EXP: repeat_count_next = '0;
            PH_ADD_SEC: begin
                adv               = 1'b1;
                second_count_next = second_count_reg + 1'b1;
            end
            default: ;
        endcase

        case (phase_reg)
            PH_INIT: phase_next = PH_NEVER;
            PH_NEVER, PH_WAIT: begin
                // A touch out of the never-touched phase always acknowledges,
                // even when the second rollover wins the transition.
                ack = touched && (phase_reg == PH_NEVER ||
                                  second_count_next != cfg.second_ticks);
                if (second_count_next == cfg.second_ticks) begin
                    phase_next        = PH_ADD_SEC;
                    second_count_next = '0;
                end else if (touched) begin
                    phase_next = PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                if (settle_count_next == cfg.settle_ticks) begin
                    if (!touched) begin
                        inc_dec    = 1'b1;
                        phase_next = PH_WAIT;
                    end else begin
                        phase_next = PH_HOLD;
                    end
                end
            end
            PH_HOLD: begin
                if (!touched) begin
                    inc_dec    = 1'b1;
                    phase_next = PH_WAIT;
                end else if (hold_count_next == cfg.hold_ticks) begin
                    inc_dec    = 1'b1;
                    phase_next = PH_REPEAT;
                end
            end
            PH_REPEAT: begin
                if (!touched) begin
                    phase_next = PH_WAIT;
                end else if (repeat_count_next == cfg.repeat_ticks) begin
                    phase_next = PH_REP_EXP;
                end
            end
            PH_REP_EXP: begin
                if (!touched) begin
                    phase_next = PH_WAIT;
                end else begin
                    inc_dec    = 1'b1;
                    phase_next = PH_REPEAT;
                end
            end
            default: phase_next = PH_WAIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_INIT;
            settle_count_reg <= '0;
            hold_count_reg   <= '0;
            repeat_count_reg <= '0;
            second_count_reg <= '0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            settle_count_reg <= settle_count_next;
            hold_count_reg   <= hold_count_next;
            repeat_count_reg <= repeat_count_next;
            second_count_reg <= second_count_next;
        end
    end

    assign result.phase          = phase_next;
    assign result.touch_ack      = ack;
    assign result.advance_second = adv;
    assign result.inc_dec_pulse  = inc_dec;

    `TARCC_ASSERT_IMPLY(a_adv_from_add_sec, aclk, aresetn,
        step_en && result.advance_second, phase_reg == PH_ADD_SEC,
        "advance pulse outside the add-second phase")
    `TARCC_ASSERT_IMPLY(a_ack_to_settle, aclk, aresetn,
        step_en && result.touch_ack && second_count_next != cfg.second_ticks,
        result.phase == PH_SETTLE, "touch acknowledge without entering settle")
    `TARCC_ASSERT_NEXT(a_add_sec_to_wait, aclk, aresetn,
        step_en && phase_reg == PH_ADD_SEC, phase_reg == PH_WAIT,
        "add-second phase did not return to wait")
    `TARCC_ASSERT_NEXT(a_hold_without_tick, aclk, aresetn,
        !step_en, $stable(phase_reg) && $stable(second_count_reg),
        "state moved without an accepted tick")

endmodule
